// File: rtl/gcd_pkg.sv
package gcd_pkg;

  // Coordinates enter as 16-bit signed values; latitude fields are sign-extended.
  localparam int COORD_W = 16;

  // Angles in Q30 radians, wide enough for sums and differences of any two inputs.
  localparam int ANG_W = 37;

  // Datapath width of the CORDIC cells.
  localparam int CW = 34;

  localparam int CORDIC_STEPS = 30;
  localparam int SQRT_STEPS   = 31;
  localparam int SQ_W         = 62;

  localparam int DIST_W = 17;
  localparam logic [DIST_W-1:0] DIAG_DISTANCE = 17'd99999;

  localparam int FIFO_AW    = 7;
  localparam int FIFO_DEPTH = 1 << FIFO_AW;

  // Registers from the accepting clock edge to the final distance register.
  localparam int PIPE_LAT = 111;

  localparam logic signed [CW-1:0] GAIN_Q30 = 34'sd652032874;
  localparam logic signed [CW-1:0] ONE_Q30  = 34'sd1073741824;

  localparam logic signed [ANG_W-1:0] PI_A      = 37'sd3373259426;
  localparam logic signed [ANG_W-1:0] HALF_PI_A = 37'sd1686629713;
  localparam logic signed [ANG_W-1:0] TWO_PI_A  = 37'sd6746518852;
  localparam logic signed [ANG_W-1:0] FOUR_PI_A = 37'sd13493037704;

  function automatic logic signed [CW-1:0] atan_q30(input logic [4:0] step);
    logic signed [CW-1:0] a;
    case (step)
      5'd0:  a = 34'sd843314857;
      5'd1:  a = 34'sd497837829;
      5'd2:  a = 34'sd263043837;
      5'd3:  a = 34'sd133525159;
      5'd4:  a = 34'sd67021687;
      5'd5:  a = 34'sd33543516;
      5'd6:  a = 34'sd16775851;
      5'd7:  a = 34'sd8388437;
      5'd8:  a = 34'sd4194283;
      5'd9:  a = 34'sd2097149;
      5'd10: a = 34'sd1048576;
      5'd11: a = 34'sd524288;
      5'd12: a = 34'sd262144;
      5'd13: a = 34'sd131072;
      5'd14: a = 34'sd65536;
      5'd15: a = 34'sd32768;
      5'd16: a = 34'sd16384;
      5'd17: a = 34'sd8192;
      5'd18: a = 34'sd4096;
      5'd19: a = 34'sd2048;
      5'd20: a = 34'sd1024;
      5'd21: a = 34'sd512;
      5'd22: a = 34'sd256;
      5'd23: a = 34'sd128;
      5'd24: a = 34'sd64;
      5'd25: a = 34'sd32;
      5'd26: a = 34'sd16;
      5'd27: a = 34'sd8;
      5'd28: a = 34'sd4;
      5'd29: a = 34'sd2;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

// File: rtl/gcd_if.sv
interface gcd_in_if;
  logic               valid;
  logic               ready;
  logic        [9:0]  row_city;
  logic        [9:0]  col_city;
  logic signed [14:0] lat_first;
  logic signed [15:0] lon_first;
  logic signed [14:0] lat_second;
  logic signed [15:0] lon_second;

  modport source (
    output valid, row_city, col_city, lat_first, lon_first, lat_second, lon_second,
    input  ready
  );
  modport sink (
    input  valid, row_city, col_city, lat_first, lon_first, lat_second, lon_second,
    output ready
  );
endinterface

interface gcd_out_if;
  logic        valid;
  logic        ready;
  logic [16:0] distance;

  modport source (output valid, distance, input ready);
  modport sink (input valid, distance, output ready);
endinterface

// File: rtl/geo_city_distance.sv
// Geographic (GEO metric) distance between two cities, fully pipelined. One city pair
// is accepted every clock cycle while ready is high; its distance passes from the final
// distance register into the 128-entry result queue and from there onto result. The
// pipeline is the chain of cells: coordinate conversion (6), range reduction (3), three
// parallel 30-cell cosine CORDICs, the combination and clamp (7), a 31-cell square root,
// a 30-cell arccosine CORDIC and the radius scaling (4). Up to 128 pairs may be in
// flight; ready falls only when that many are accepted but their results not yet taken,
// so a stalled consumer never stalls the pipeline itself. Equal city indices give 99999.
module geo_city_distance (
  input  logic     clk,
  input  logic     rst,
  gcd_in_if.sink   pair,
  gcd_out_if.source result
);
  import gcd_pkg::*;

  localparam logic [22:0] RADIUS_MILLI = 23'd6378388;
  localparam logic [25:0] KM_RECIP = 26'((64'd1 << 35) / 1000);

  function automatic logic signed [ANG_W-1:0] wrap_2pi(input logic signed [ANG_W-1:0] a);
    logic signed [ANG_W-1:0] up1, up2, dn1, dn2, r;
    up1 = a + TWO_PI_A;
    up2 = a + FOUR_PI_A;
    dn1 = a - TWO_PI_A;
    dn2 = a - FOUR_PI_A;
    if (a < 0) begin
      r = (up1 >= 0) ? up1 : up2;
    end else if (dn1 < 0) begin
      r = a;
    end else if (dn2 < 0) begin
      r = dn1;
    end else begin
      r = dn2;
    end
    return r;
  endfunction

  logic                 accept;
  logic                 take;
  logic [FIFO_AW:0]     credits;

  logic [PIPE_LAT-1:0]  vld;
  logic [PIPE_LAT-2:0]  diag;

  logic signed [ANG_W-1:0] la1, lo1, la2, lo2;
  logic signed [ANG_W-1:0] arg  [3];
  logic signed [ANG_W-1:0] rmod [3];
  logic signed [ANG_W-1:0] fold [3];
  logic signed [CW-1:0]    zred [3];
  logic [2:0]              neg;
  logic [CORDIC_STEPS-1:0] negd [3];

  logic signed [CW-1:0] cx [3][CORDIC_STEPS+1];
  logic signed [CW-1:0] cy [3][CORDIC_STEPS+1];
  logic signed [CW-1:0] cz [3][CORDIC_STEPS+1];

  logic signed [CW-1:0] qcos [3];
  logic signed [32:0]   pf, mf;
  logic signed [31:0]   q2f, q3f;
  logic signed [64:0]   pp, mq;
  logic signed [65:0]   sum;
  logic signed [65:0]   shifted;
  logic signed [31:0]   c;
  logic        [63:0]   cc;
  logic        [31:0]   x0j, x0k;
  logic                 cnegj, cnegk;
  logic        [SQ_W-1:0] nsq;
  logic        [31:0]   x0d [SQRT_STEPS];
  logic [CORDIC_STEPS+SQRT_STEPS-1:0] cnegd;

  logic [SQ_W-1:0] sn [SQRT_STEPS+1];
  logic [SQ_W-1:0] sr [SQRT_STEPS+1];

  logic signed [CW-1:0] ax [CORDIC_STEPS+1];
  logic signed [CW-1:0] ay [CORDIC_STEPS+1];
  logic signed [CW-1:0] az [CORDIC_STEPS+1];

  logic signed [ANG_W-1:0] zpost;
  logic        [31:0]   ang;
  logic        [54:0]   pm;
  logic        [24:0]   unc, un;
  logic        [50:0]   pn;
  logic        [15:0]   qk;
  logic        [24:0]   remk;
  logic        [15:0]   qkc;
  logic [DIST_W-1:0]    dist_out;

  // Admission: each accepted pair holds a credit until its result is taken.
  always_comb begin
    pair.ready = credits < (FIFO_AW+1)'(FIFO_DEPTH);
    accept     = pair.valid && pair.ready;
    take       = result.valid && result.ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      credits <= '0;
      vld     <= '0;
    end else begin
      credits <= credits + (FIFO_AW+1)'(accept) - (FIFO_AW+1)'(take);
      vld     <= {vld[PIPE_LAT-2:0], accept};
    end
  end

  always_ff @(posedge clk) begin
    diag <= {diag[PIPE_LAT-3:0], pair.row_city == pair.col_city};
  end

  gcd_conv u_conv_la1 (.clk(clk), .coord(COORD_W'(pair.lat_first)),  .angle(la1));
  gcd_conv u_conv_lo1 (.clk(clk), .coord(pair.lon_first),            .angle(lo1));
  gcd_conv u_conv_la2 (.clk(clk), .coord(COORD_W'(pair.lat_second)), .angle(la2));
  gcd_conv u_conv_lo2 (.clk(clk), .coord(pair.lon_second),           .angle(lo2));

  // Range reduction into [0, pi/2] with the sign of the cosine kept aside.
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      rmod[l] = wrap_2pi(arg[l]);
    end
  end

  always_ff @(posedge clk) begin
    arg[0] <= lo1 - lo2;
    arg[1] <= la1 - la2;
    arg[2] <= la1 + la2;
    for (int l = 0; l < 3; l++) begin
      fold[l] <= (rmod[l] > PI_A) ? TWO_PI_A - rmod[l] : rmod[l];
      if (fold[l] > HALF_PI_A) begin
        zred[l] <= CW'(PI_A - fold[l]);
        neg[l]  <= 1'b1;
      end else begin
        zred[l] <= CW'(fold[l]);
        neg[l]  <= 1'b0;
      end
      negd[l] <= {negd[l][CORDIC_STEPS-2:0], neg[l]};
    end
  end

  for (genvar l = 0; l < 3; l++) begin : g_cos
    assign cx[l][0] = GAIN_Q30;
    assign cy[l][0] = '0;
    assign cz[l][0] = zred[l];
    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cell
      gcd_cordic_cell u_cell (
        .clk  (clk),
        .vec  (1'b0),
        .step (5'(k)),
        .x_in (cx[l][k]),
        .y_in (cy[l][k]),
        .z_in (cz[l][k]),
        .x    (cx[l][k+1]),
        .y    (cy[l][k+1]),
        .z    (cz[l][k+1])
      );
    end
  end

  // 0.5*((1+q1)*q2 - (1-q1)*q3), rounded from Q61 back to Q30.
  always_comb begin
    shifted = sum >>> 31;
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < 3; l++) begin
      qcos[l] <= negd[l][CORDIC_STEPS-1] ? -cx[l][CORDIC_STEPS] : cx[l][CORDIC_STEPS];
    end
    pf  <= 33'(ONE_Q30 + qcos[0]);
    mf  <= 33'(ONE_Q30 - qcos[0]);
    q2f <= 32'(qcos[1]);
    q3f <= 32'(qcos[2]);
    pp  <= 65'(pf * q2f);
    mq  <= 65'(mf * q3f);
    sum <= 66'(pp) - 66'(mq) + 66'(ONE_Q30);
    if (shifted > 66'(ONE_Q30)) begin
      c <= 32'(ONE_Q30);
    end else if (shifted < -66'(ONE_Q30)) begin
      c <= -32'(ONE_Q30);
    end else begin
      c <= 32'(shifted);
    end
    cc    <= 64'(c * c);
    x0j   <= c[31] ? 32'(-c) : 32'(c);
    cnegj <= c[31];
    nsq   <= SQ_W'((64'd1 << 60) - cc);
    x0k   <= x0j;
    cnegk <= cnegj;
    x0d[0] <= x0k;
    for (int i = 1; i < SQRT_STEPS; i++) begin
      x0d[i] <= x0d[i-1];
    end
    cnegd <= {cnegd[CORDIC_STEPS+SQRT_STEPS-2:0], cnegk};
  end

  // Square root of 1 - c*c, one result bit per cell.
  assign sn[0] = nsq;
  assign sr[0] = '0;
  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    gcd_sqrt_cell u_cell (
      .clk  (clk),
      .step (5'(k)),
      .n_in (sn[k]),
      .r_in (sr[k]),
      .n    (sn[k+1]),
      .r    (sr[k+1])
    );
  end

  assign ax[0] = CW'(x0d[SQRT_STEPS-1]);
  assign ay[0] = CW'(sr[SQRT_STEPS][30:0]);
  assign az[0] = '0;
  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_acos
    gcd_cordic_cell u_cell (
      .clk  (clk),
      .vec  (1'b1),
      .step (5'(k)),
      .x_in (ax[k]),
      .y_in (ay[k]),
      .z_in (az[k]),
      .x    (ax[k+1]),
      .y    (ay[k+1]),
      .z    (az[k+1])
    );
  end

  always_comb begin
    zpost = cnegd[CORDIC_STEPS+SQRT_STEPS-1] ? PI_A - ANG_W'(az[CORDIC_STEPS])
                                              : ANG_W'(az[CORDIC_STEPS]);
    unc   = pm[54:30];
    qk    = pn[50:35];
    remk  = un - 25'(qk) * 25'd1000;
    qkc   = (remk >= 25'd1000) ? qk + 16'd1 : qk;
  end

  always_ff @(posedge clk) begin
    ang      <= (zpost < 0) ? '0 : 32'(zpost);
    pm       <= 55'(ang * RADIUS_MILLI);
    un       <= unc;
    pn       <= 51'(unc * KM_RECIP);
    dist_out <= diag[PIPE_LAT-2] ? DIAG_DISTANCE : DIST_W'(qkc + 16'd1);
  end

  gcd_ofifo u_ofifo (
    .clk     (clk),
    .rst     (rst),
    .wr      (vld[PIPE_LAT-1]),
    .wr_data (dist_out),
    .result  (result)
  );

endmodule

// File: rtl/gcd_conv.sv
module gcd_conv (
  input  logic                              clk,
  input  logic signed [gcd_pkg::COORD_W-1:0] coord,
  output logic signed [gcd_pkg::ANG_W-1:0]   angle
);
  import gcd_pkg::*;

  // floor(v/100) is taken on v + 32800, which is never negative.
  localparam logic [17:0] DEG_RECIP = 18'((64'd1 << 24) / 100);
  // PI in Q30 is 10800 * QT_MULT + 9026; RT_MULT is 8324, so QT_MULT and RT_MULT fall 702 short.
  localparam logic signed [19:0] QT_MULT = 20'sd312338;
  localparam logic signed [14:0] RT_MULT = 15'sd8324;
  localparam logic signed [30:0] REM_BIAS = 31'sd176947200;
  localparam logic [29:0] REM_RECIP = 30'((64'd1 << 43) / 10800);

  logic signed [17:0] ushift;
  logic        [16:0] u1;
  logic signed [15:0] v1;
  logic        [34:0] p1;

  logic        [10:0] q2;
  logic        [17:0] rem2;
  logic        [10:0] qc2;
  logic signed [11:0] deg2;
  logic signed [17:0] t2;
  logic signed [15:0] t3;

  logic signed [35:0] qt3;
  logic signed [30:0] rt3;
  logic        [28:0] u4;
  logic signed [35:0] qt4;
  logic        [58:0] p5;
  logic        [28:0] u5;
  logic signed [35:0] qt5;

  logic        [15:0] q6;
  logic        [28:0] rem6;
  logic        [15:0] qc6;

  always_comb begin
    ushift = 18'(coord) + 18'sd32800;
    q2     = p1[34:24];
    rem2   = 18'(u1) - 18'(q2) * 18'd100;
    qc2    = (rem2 >= 18'd100) ? q2 + 11'd1 : q2;
    deg2   = $signed({1'b0, qc2}) - 12'sd328;
    // Degrees plus minutes in minutes: 60*deg + (v - 100*deg).
    t2     = 18'(v1) - 18'(deg2) * 18'sd40;
    q6     = p5[58:43];
    rem6   = u5 - 29'(q6) * 29'd10800;
    qc6    = (rem6 >= 29'd10800) ? q6 + 16'd1 : q6;
  end

  always_ff @(posedge clk) begin
    u1    <= ushift[16:0];
    v1    <= coord;
    p1    <= 35'(ushift[16:0] * DEG_RECIP);
    t3    <= 16'(t2);
    qt3   <= 36'(t3 * QT_MULT);
    rt3   <= 31'(t3 * RT_MULT);
    u4    <= 29'(rt3 + 31'sd5400 + REM_BIAS);
    qt4   <= qt3;
    p5    <= 59'(u4 * REM_RECIP);
    u5    <= u4;
    qt5   <= qt4;
    angle <= ANG_W'(qt5) + ANG_W'($signed({1'b0, qc6})) - 37'sd16384;
  end

endmodule

// File: rtl/gcd_cordic_cell.sv
module gcd_cordic_cell (
  input  logic                          clk,
  input  logic                          vec,
  input  logic [4:0]                    step,
  input  logic signed [gcd_pkg::CW-1:0] x_in,
  input  logic signed [gcd_pkg::CW-1:0] y_in,
  input  logic signed [gcd_pkg::CW-1:0] z_in,
  output logic signed [gcd_pkg::CW-1:0] x,
  output logic signed [gcd_pkg::CW-1:0] y,
  output logic signed [gcd_pkg::CW-1:0] z
);
  import gcd_pkg::*;

  logic signed [CW-1:0] dx;
  logic signed [CW-1:0] dy;
  logic signed [CW-1:0] ang;
  logic                 pos;

  always_comb begin
    dx  = y_in >>> step;
    dy  = x_in >>> step;
    ang = atan_q30(step);
    // Rotation mode follows the residual angle, vectoring mode drives y to zero.
    pos = vec ? (y_in <= 0) : (z_in >= 0);
  end

  always_ff @(posedge clk) begin
    if (pos) begin
      x <= x_in - dx;
      y <= y_in + dy;
      z <= z_in - ang;
    end else begin
      x <= x_in + dx;
      y <= y_in - dy;
      z <= z_in + ang;
    end
  end

endmodule

// File: rtl/gcd_sqrt_cell.sv
module gcd_sqrt_cell (
  input  logic                      clk,
  input  logic [4:0]                step,
  input  logic [gcd_pkg::SQ_W-1:0]  n_in,
  input  logic [gcd_pkg::SQ_W-1:0]  r_in,
  output logic [gcd_pkg::SQ_W-1:0]  n,
  output logic [gcd_pkg::SQ_W-1:0]  r
);
  import gcd_pkg::*;

  logic [5:0]      sh;
  logic [SQ_W-1:0] bitv;
  logic [SQ_W-1:0] trial;

  always_comb begin
    sh    = 6'(2 * (SQRT_STEPS - 1)) - {step, 1'b0};
    bitv  = SQ_W'(1) << sh;
    trial = r_in + bitv;
  end

  always_ff @(posedge clk) begin
    if (n_in >= trial) begin
      n <= n_in - trial;
      r <= (r_in >> 1) + bitv;
    end else begin
      n <= n_in;
      r <= r_in >> 1;
    end
  end

endmodule

// File: rtl/gcd_ofifo.sv
module gcd_ofifo (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        wr,
  input  logic [gcd_pkg::DIST_W-1:0]  wr_data,
  gcd_out_if.source                   result
);
  import gcd_pkg::*;

  logic [DIST_W-1:0]  mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_AW:0]   cnt;
  logic               take;
  logic               load;

  always_comb begin
    take = result.valid && result.ready;
    load = (cnt != '0) && (!result.valid || take);
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= wr_data;
    end
    if (load) begin
      result.distance <= mem[rd_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr       <= '0;
      rd_ptr       <= '0;
      cnt          <= '0;
      result.valid <= 1'b0;
    end else begin
      if (wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (load) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      cnt <= cnt + (FIFO_AW+1)'(wr) - (FIFO_AW+1)'(load);
      if (load) begin
        result.valid <= 1'b1;
      end else if (take) begin
        result.valid <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/gcd_checker.sv
module gcd_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [16:0] distance
);

  // A result waiting on the consumer holds its beat.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(distance))
    else $error("result beat changed while stalled");

  // Every distance is at least one, and no result exceeds the diagonal marker.
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> distance != 17'd0 && distance <= 17'd99999)
    else $error("distance out of range");

  a_rst_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // With nothing in flight the block must take a new pair.
  a_rst_ready: assert property (@(posedge clk) rst |=> in_ready)
    else $error("not ready after reset");

endmodule

bind geo_city_distance gcd_checker u_gcd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (pair.ready),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .distance  (result.distance)
);
